>>> hdl/fnm_pkg.sv
// Shared types, constants and an arithmetic helper of the four-neighbour mean filter.
`timescale 1ns / 1ps

package fnm_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam int PIXEL_W = 8;
    localparam int ROW_W   = 16;
    localparam int MEAN_W  = 16;
    localparam int SUM_W   = 10;
    localparam int CNT_W   = 3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FW_W        = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    localparam int RECIP3   = 683;
    localparam int RECIP3_S = 11;
    localparam int PROD_W   = 21;

    typedef struct packed {
        logic first_row;
        logic row_ge2;
        logic col_gt0;
        logic col_gt1;
        logic last_col;
        logic last_row;
    } pos_flags_t;

    // floor(sum * 256 / cnt) for cnt of 2, 3 or 4
    function automatic logic [MEAN_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                                  input logic [CNT_W-1:0] cnt);
        logic [PROD_W-1:0] third;
        logic [PROD_W-1:0] scaled;
        logic [MEAN_W-1:0] res;
        third  = (PROD_W'(sum) * PROD_W'(RECIP3)) >> RECIP3_S;
        scaled = PROD_W'(sum) * PROD_W'(85);
        case (cnt)
            CNT_W'(2): res = MEAN_W'({sum, 7'b0});
            CNT_W'(3): res = MEAN_W'(scaled + third);
            default:   res = MEAN_W'({sum, 6'b0});
        endcase
        return res;
    endfunction

endpackage

>>> hdl/fnm_ram.sv
// Generic RAM: one write port, two registered read ports, read-first.
`timescale 1ns / 1ps

module fnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> hdl/fnm_pos.sv
// Frame geometry registers and raster position counters.
`timescale 1ns / 1ps

module fnm_pos #(
    parameter int MAX_WIDTH = fnm_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fnm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fnm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               advance,
    output logic [fnm_pkg::ROW_W-1:0]          row,
    output logic [$clog2(MAX_WIDTH)-1:0]       col,
    output fnm_pkg::pos_flags_t                flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0]          last_col_reg, last_col_next;
    logic [fnm_pkg::ROW_W-1:0] last_row_reg, last_row_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [fnm_pkg::ROW_W-1:0] row_reg, row_next;
    logic [fnm_pkg::FW_W-1:0]  fw;

    assign fw = cfg_data[fnm_pkg::FW_W-1:0];

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                fnm_pkg::REG_FRAME_WIDTH:
                begin
                    if (fw < fnm_pkg::FW_W'(2))
                        last_col_next = COL_W'(1);
                    else if (32'(fw) > MAX_WIDTH)
                        last_col_next = COL_W'(MAX_WIDTH - 1);
                    else
                        last_col_next = COL_W'(fw - fnm_pkg::FW_W'(1));
                    col_next = '0;
                    row_next = '0;
                end
                fnm_pkg::REG_FRAME_HEIGHT:
                begin
                    if (cfg_data < fnm_pkg::CFG_DATA_W'(2))
                        last_row_next = fnm_pkg::ROW_W'(1);
                    else
                        last_row_next = fnm_pkg::ROW_W'(cfg_data - fnm_pkg::CFG_DATA_W'(1));
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (advance)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + fnm_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= COL_W'(2);
            last_row_reg <= fnm_pkg::ROW_W'(2);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    assign row             = row_reg;
    assign col             = col_reg;
    assign flags.first_row = (row_reg == '0);
    assign flags.row_ge2   = (row_reg > fnm_pkg::ROW_W'(1));
    assign flags.col_gt0   = (col_reg != '0);
    assign flags.col_gt1   = (col_reg > COL_W'(1));
    assign flags.last_col  = (col_reg == last_col_reg);
    assign flags.last_row  = (row_reg == last_row_reg);

endmodule

>>> hdl/fnm_emit.sv
// Result stage: neighbour sums, means and the output register.
`timescale 1ns / 1ps

module fnm_emit #(
    parameter int MAX_WIDTH = fnm_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [fnm_pkg::PIXEL_W-1:0]        in_pixel,
    input  logic [fnm_pkg::ROW_W-1:0]          in_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]       in_col,
    input  fnm_pkg::pos_flags_t                in_flags,
    input  logic [fnm_pkg::PIXEL_W-1:0]        ram0_a,
    input  logic [fnm_pkg::PIXEL_W-1:0]        ram0_b,
    input  logic [fnm_pkg::PIXEL_W-1:0]        ram1_a,
    input  logic [fnm_pkg::PIXEL_W-1:0]        ram1_b,
    output logic                               take_ready,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [fnm_pkg::ROW_W-1:0]          out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]       out_col,
    output logic [fnm_pkg::MEAN_W-1:0]         out_mean,
    output logic                               out_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int SW    = fnm_pkg::SUM_W;
    localparam int CW    = fnm_pkg::CNT_W;

    logic [2:0]                   mask_reg, mask_next;
    logic                         out_valid_reg, out_valid_next;
    logic [fnm_pkg::PIXEL_W-1:0]  b_pixel_reg;
    logic [fnm_pkg::ROW_W-1:0]    b_row_reg;
    logic [COL_W-1:0]             b_col_reg;
    fnm_pkg::pos_flags_t          b_flags_reg;
    logic [fnm_pkg::PIXEL_W-1:0]  hist_reg;
    logic [fnm_pkg::PIXEL_W-1:0]  cur1_reg;
    logic [fnm_pkg::PIXEL_W-1:0]  cur2_reg;
    logic [fnm_pkg::ROW_W-1:0]    out_row_reg;
    logic [COL_W-1:0]             out_col_reg;
    logic [fnm_pkg::MEAN_W-1:0]   out_mean_reg;
    logic                         out_last_reg;

    logic [fnm_pkg::PIXEL_W-1:0]  cur_a, prev_a, prev_b;
    logic [2:0]                   low;
    logic                         busy, single, out_free, emit_now;
    logic [SW-1:0]                sum1, sum2, sum3, sel_sum;
    logic [CW-1:0]                cnt1, cnt2, sel_cnt;
    logic [fnm_pkg::ROW_W-1:0]    sel_row;
    logic [COL_W-1:0]             sel_col;
    logic [2:0]                   load_mask;

    assign cur_a  = b_row_reg[0] ? ram1_a : ram0_a;
    assign prev_a = b_row_reg[0] ? ram0_a : ram1_a;
    assign prev_b = b_row_reg[0] ? ram0_b : ram1_b;

    assign low      = mask_reg & (~mask_reg + 3'd1);
    assign busy     = (mask_reg != 3'b000);
    assign single   = ((mask_reg & (mask_reg - 3'd1)) == 3'b000);
    assign out_free = !out_valid_reg || out_ready;
    assign emit_now = busy && out_free;

    assign take_ready = !busy || (out_free && single);

    assign load_mask = {in_flags.last_row && in_flags.last_col,
                        in_flags.last_row && in_flags.col_gt0,
                        !in_flags.first_row};

    always_comb
    begin
        sum1 = SW'(b_pixel_reg)
             + (b_flags_reg.row_ge2   ? SW'(cur_a)    : SW'(0))
             + (b_flags_reg.col_gt0   ? SW'(hist_reg) : SW'(0))
             + (!b_flags_reg.last_col ? SW'(prev_b)   : SW'(0));
        cnt1 = CW'(1) + CW'(b_flags_reg.row_ge2) + CW'(b_flags_reg.col_gt0)
             + CW'(!b_flags_reg.last_col);
        sum2 = SW'(hist_reg) + SW'(b_pixel_reg)
             + (b_flags_reg.col_gt1 ? SW'(cur2_reg) : SW'(0));
        cnt2 = CW'(2) + CW'(b_flags_reg.col_gt1);
        sum3 = SW'(prev_a) + SW'(cur1_reg);
        case (low)
            3'b001:
            begin
                sel_sum = sum1;
                sel_cnt = cnt1;
                sel_row = b_row_reg - fnm_pkg::ROW_W'(1);
                sel_col = b_col_reg;
            end
            3'b010:
            begin
                sel_sum = sum2;
                sel_cnt = cnt2;
                sel_row = b_row_reg;
                sel_col = b_col_reg - COL_W'(1);
            end
            default:
            begin
                sel_sum = sum3;
                sel_cnt = CW'(2);
                sel_row = b_row_reg;
                sel_col = b_col_reg;
            end
        endcase
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
            mask_next = load_mask;
        else if (emit_now)
            mask_next = mask_reg & ~low;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_now)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_pixel_reg <= in_pixel;
            b_row_reg   <= in_row;
            b_col_reg   <= in_col;
            b_flags_reg <= in_flags;
            hist_reg    <= prev_a;
            cur1_reg    <= b_pixel_reg;
            cur2_reg    <= cur1_reg;
        end
        if (emit_now)
        begin
            out_row_reg  <= sel_row;
            out_col_reg  <= sel_col;
            out_mean_reg <= fnm_pkg::mean_of(sel_sum, sel_cnt);
            out_last_reg <= single;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_mean  = out_mean_reg;
    assign out_last  = out_last_reg;

endmodule

>>> hdl/four_neighbour_mean_filter.sv
// Top level of the four-neighbour mean filter.
`timescale 1ns / 1ps

// Pixels stream in raster order, one per cycle while s_tready is high; each pixel is
// written into one of two line RAMs (selected by row parity) while the same cycle
// reads the row two above at the current column and the row above at the current and
// next column. A mean is built from the registered reads into the output register. The
// first row yields no result and each later row except the last yields one result per
// pixel, so the block sustains one pixel per clock there while the output is not
// stalled; in the last row a pixel yields two results (one at the first column, three
// at the last) and the single output register, which takes one result per clock, holds
// the input back while a pixel's results drain. Writing frame_width or frame_height
// restarts the frame; the line RAMs are not cleared after reset.
module four_neighbour_mean_filter #(
    parameter int MAX_WIDTH = fnm_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_row, out_col, mean_value, zero fill
    output logic [((fnm_pkg::ROW_W + $clog2(MAX_WIDTH) + fnm_pkg::MEAN_W + 7) / 8) * 8 - 1:0]
                                                m_tdata,
    output logic                                m_tlast,   // run_last
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fnm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fnm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int OUT_BITS    = fnm_pkg::ROW_W + COL_W + fnm_pkg::MEAN_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    logic                          in_fire;
    logic                          take_ready;
    logic [fnm_pkg::ROW_W-1:0]     row;
    logic [COL_W-1:0]              col;
    logic [COL_W-1:0]              col_next_addr;
    fnm_pkg::pos_flags_t           flags;
    logic [fnm_pkg::PIXEL_W-1:0]   ram0_a, ram0_b, ram1_a, ram1_b;
    logic [fnm_pkg::ROW_W-1:0]     out_row;
    logic [COL_W-1:0]              out_col;
    logic [fnm_pkg::MEAN_W-1:0]    out_mean;

    assign s_tready      = take_ready;
    assign in_fire       = s_tvalid && take_ready;
    assign cfg_ready     = 1'b1;
    assign col_next_addr = col + COL_W'(1);

    fnm_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_fire),
        .row       (row),
        .col       (col),
        .flags     (flags)
    );

    fnm_ram #(
        .WIDTH (fnm_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram0 (
        .clk     (clk),
        .we      (in_fire && !row[0]),
        .waddr   (col),
        .wdata   (s_tdata),
        .re      (in_fire),
        .raddr_a (col),
        .raddr_b (col_next_addr),
        .rdata_a (ram0_a),
        .rdata_b (ram0_b)
    );

    fnm_ram #(
        .WIDTH (fnm_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram1 (
        .clk     (clk),
        .we      (in_fire && row[0]),
        .waddr   (col),
        .wdata   (s_tdata),
        .re      (in_fire),
        .raddr_a (col),
        .raddr_b (col_next_addr),
        .rdata_a (ram1_a),
        .rdata_b (ram1_b)
    );

    fnm_emit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .in_pixel   (s_tdata),
        .in_row     (row),
        .in_col     (col),
        .in_flags   (flags),
        .ram0_a     (ram0_a),
        .ram0_b     (ram0_b),
        .ram1_a     (ram1_a),
        .ram1_b     (ram1_b),
        .take_ready (take_ready),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_mean   (out_mean),
        .out_last   (m_tlast)
    );

    assign m_tdata = OUT_TDATA_W'({out_mean, out_col, out_row});

endmodule

>>> hdl/fnm_checker.sv
// Port-level checks of the four-neighbour mean filter, bound to the top level.
`timescale 1ns / 1ps

module fnm_checker #(
    parameter int MAX_WIDTH = fnm_pkg::MAX_WIDTH_DEFAULT
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((fnm_pkg::ROW_W + $clog2(MAX_WIDTH) + fnm_pkg::MEAN_W + 7) / 8) * 8 - 1:0]
                                               m_tdata,
    input logic                                m_tlast,
    input logic                                cfg_valid,
    input logic                                cfg_ready
);

    localparam int MEAN_LO = fnm_pkg::ROW_W + $clog2(MAX_WIDTH);

    logic [fnm_pkg::MEAN_W-1:0] mean;

    assign mean = m_tdata[MEAN_LO +: fnm_pkg::MEAN_W];

    // hold a stalled transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> mean <= fnm_pkg::MEAN_W'(16'hFF00))
        else $error("mean above full scale");

    // input stalls only while results drain into the output
    a_stall_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> m_tvalid)
        else $error("input stalled with nothing to deliver");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind four_neighbour_mean_filter fnm_checker #(
    .MAX_WIDTH (MAX_WIDTH)
) u_fnm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

>>> sim/mean_checker.sv
// Checker for the four-neighbour mean filter: predicts means and compares transfers.
`timescale 1ns / 1ps

module mean_checker #(
    parameter int TDATA_W = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [TDATA_W-1:0]                  m_tdata,
    input  logic                                m_tlast,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [fnm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fnm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  pixels_seen,
    output int                                  means_seen
);

    localparam int MAX_W   = fnm_pkg::MAX_WIDTH_DEFAULT;
    localparam int ROW_W   = fnm_pkg::ROW_W;
    localparam int MEAN_W  = fnm_pkg::MEAN_W;
    localparam int PIXEL_W = fnm_pkg::PIXEL_W;
    localparam int FW_W    = fnm_pkg::FW_W;
    localparam int COL_W   = $clog2(MAX_W);
    localparam int COL_LO  = ROW_W;
    localparam int MEAN_LO = ROW_W + COL_W;
    localparam int PAD_LO  = MEAN_LO + MEAN_W;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [MEAN_W-1:0] mean;
        logic              last;
    } mean_t;

    mean_t             mean_queue [$];
    logic [PIXEL_W-1:0] older_line  [MAX_W];
    logic [PIXEL_W-1:0] recent_line [MAX_W];
    logic [FW_W-1:0]    frame_width;
    logic [ROW_W-1:0]   frame_height;
    int                 row_pos;
    int                 col_pos;

    function automatic mean_t mean_entry(input int row, input int col, input int sum,
                                         input int cnt);
        mean_t m;
        m.row  = ROW_W'(row);
        m.col  = COL_W'(col);
        m.mean = MEAN_W'((sum * 256) / cnt);
        m.last = 1'b0;
        return m;
    endfunction

    task automatic predict_means(input logic [PIXEL_W-1:0] p);
        mean_t found [3];
        int    w;
        int    h;
        int    r;
        int    c;
        int    sum;
        int    cnt;
        int    n;
        w = int'(frame_width);
        if (w < 2)
            w = 2;
        if (w > MAX_W)
            w = MAX_W;
        h = int'(frame_height);
        if (h < 2)
            h = 2;
        r = row_pos;
        c = col_pos;
        n = 0;
        if (c >= w)
            c = 0;
        if (r >= h)
            r = 0;
        // the position above this pixel now has all its neighbours
        if (r > 0)
        begin
            sum = p;
            cnt = 1;
            if (r > 1)
            begin
                sum += older_line[c];
                cnt++;
            end
            if (c > 0)
            begin
                sum += older_line[c-1];
                cnt++;
            end
            if (c + 1 < w)
            begin
                sum += recent_line[c+1];
                cnt++;
            end
            found[n] = mean_entry(r - 1, c, sum, cnt);
            n++;
        end
        older_line[c]  = recent_line[c];
        recent_line[c] = p;
        if (r == h - 1)
        begin
            if (c > 0)
            begin
                sum = older_line[c-1];
                sum += p;
                cnt = 2;
                if (c > 1)
                begin
                    sum += recent_line[c-2];
                    cnt++;
                end
                found[n] = mean_entry(r, c - 1, sum, cnt);
                n++;
            end
            if (c == w - 1)
            begin
                sum = older_line[c];
                sum += recent_line[c-1];
                found[n] = mean_entry(r, c, sum, 2);
                n++;
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
        for (int k = 0; k < n; k++)
        begin
            found[k].last = (k == n - 1);
            mean_queue.push_back(found[k]);
        end
    endtask

    task automatic check_mean();
        mean_t              want;
        logic [ROW_W-1:0]   got_row;
        logic [COL_W-1:0]   got_col;
        logic [MEAN_W-1:0]  got_mean;
        got_row  = m_tdata[COL_LO-1:0];
        got_col  = m_tdata[MEAN_LO-1:COL_LO];
        got_mean = m_tdata[PAD_LO-1:MEAN_LO];
        means_seen++;
        if (mean_queue.size() == 0)
        begin
            $error("mean for row %0d col %0d arrived with none expected", got_row, got_col);
            fail_count++;
        end
        else
        begin
            want = mean_queue.pop_front();
            if (got_row !== want.row)
            begin
                $error("out_row: expected %0d, got %0d", want.row, got_row);
                fail_count++;
            end
            if (got_col !== want.col)
            begin
                $error("out_col: expected %0d, got %0d", want.col, got_col);
                fail_count++;
            end
            if (got_mean !== want.mean)
            begin
                $error("mean_value: expected %0d, got %0d", want.mean, got_mean);
                fail_count++;
            end
            if (m_tlast !== want.last)
            begin
                $error("run_last: expected %0d, got %0d", want.last, m_tlast);
                fail_count++;
            end
        end
        if (m_tdata[TDATA_W-1:PAD_LO] !== '0)
        begin
            $error("zero fill: expected 0, got %0h", m_tdata[TDATA_W-1:PAD_LO]);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width  = FW_W'(3);
            frame_height = ROW_W'(3);
            row_pos      = 0;
            col_pos      = 0;
            mean_queue.delete();
        end
        else
        begin
            // retire before predicting so a mean never matches its own pixel's transfer
            if (m_tvalid && m_tready)
                check_mean();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fnm_pkg::REG_FRAME_WIDTH)
                begin
                    frame_width = cfg_data[FW_W-1:0];
                    row_pos     = 0;
                    col_pos     = 0;
                end
                else if (cfg_index == fnm_pkg::REG_FRAME_HEIGHT)
                begin
                    frame_height = cfg_data[ROW_W-1:0];
                    row_pos      = 0;
                    col_pos      = 0;
                end
            end
            if (s_tvalid && s_tready)
            begin
                pixels_seen++;
                predict_means(s_tdata);
            end
        end
        pending <= mean_queue.size();
    end

endmodule

>>> sim/tb.sv
// Testbench top for the four-neighbour mean filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int CFG_INDEX_W    = fnm_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W     = fnm_pkg::CFG_DATA_W;
    localparam int COL_W          = $clog2(fnm_pkg::MAX_WIDTH_DEFAULT);
    localparam int TDATA_W        = ((fnm_pkg::ROW_W + COL_W + fnm_pkg::MEAN_W + 7) / 8) * 8;
    localparam int TOTAL_PIXELS   = 220;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int IDLE_PCT       = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(3);

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   pixels_seen;
    int   means_seen;
    int   pixels_sent   = 0;
    int   reg_writes    = 0;
    int   cycle_count   = 0;
    logic tx_gaps       = 1'b0;
    logic rx_stalls     = 1'b0;
    logic rx_hold_req   = 1'b0;
    logic rx_hold_taken = 1'b0;

    four_neighbour_mean_filter i_dut (.*);

    mean_checker #(.TDATA_W(TDATA_W)) i_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output side: random stalls plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_req && !rx_hold_taken)
            begin
                rx_hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !rx_stalls || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] value);
        while (tx_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(pick_pixel());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height);
        settle();
        write_reg(fnm_pkg::REG_FRAME_WIDTH, width);
        write_reg(fnm_pkg::REG_FRAME_HEIGHT, height);
    endtask

    initial
    begin
        int w;
        int h;
        repeat (12) @(posedge clk);
        rst_n     <= 1'b1;
        rx_stalls <= 1'b1;
        tx_gaps    = 1'b1;
        @(posedge clk);

        // reset size 3x3: saturated frame, then checkerboard of the extremes
        repeat (9) send_pixel(8'hFF);
        for (int i = 0; i < 9; i++)
        begin
            // hold the output off while the middle row streams
            if (i == 4)
                rx_hold_req <= 1'b1;
            send_pixel(i[0] ? 8'h00 : 8'hFF);
        end

        // spare indexes mid-frame must not restart it
        send_pixels(4);
        settle();
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        send_pixels(5);

        // clamped widest row, cut short
        set_frame(16'hFFFF, 16'd2);
        send_pixels(16);

        // sizes below the minimum act as 2
        set_frame(16'd0, 16'd0);
        send_pixels(8);
        set_frame(16'd1, 16'd1);
        send_pixels(4);
        // tallest frame, left unfinished
        set_frame(16'd2, 16'hFFFF);
        send_pixels(12);

        // pause mid-frame until every mean is out
        set_frame(16'd4, 16'd3);
        send_pixels(6);
        drain();
        send_pixels(6);

        // long stretch with no idling on either side
        set_frame(16'd24, 16'd2);
        tx_gaps    = 1'b0;
        rx_stalls <= 1'b0;
        send_pixels(48);
        settle();
        tx_gaps    = 1'b1;
        rx_stalls <= 1'b1;

        while (pixels_sent < TOTAL_PIXELS)
        begin
            case ($urandom_range(9))
                0:       w = $urandom_range(8, 12);
                1:       w = 2;
                default: w = $urandom_range(2, 6);
            endcase
            h = $urandom_range(2, 5);
            set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
            send_pixels(w * h);
            // cut a frame short now and then
            if ($urandom_range(3) == 0)
                send_pixels($urandom_range(1, w * h - 1));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("checked %0d means from %0d pixels across %0d register writes",
                 means_seen, pixels_seen, reg_writes);
        $display("frames 2x2 to 24 wide, clamped sizes, gaps, a quiet run, hold and drain");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
